>>> hdl/clcr_pkg.sv
// ----------------------------------------------------------------------------
// clcr_pkg
// shared types for the centered-rectangle line clipper
// ----------------------------------------------------------------------------
package clcr_pkg;

   // control that rides along each pipeline stage
   typedef struct packed {
      logic valid;   // stage holds a word
      logic tag;     // pass-through flag from an earlier pass
      logic moved;   // point was outside and got moved onto an edge
   } clcr_ctl_type;

endpackage

>>> hdl/clcr_req_if.sv
// ----------------------------------------------------------------------------
// clcr_req_if
// request channel: start point, rectangle center and size
// ----------------------------------------------------------------------------
interface clcr_req_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] center_x;
   logic signed [COORD_WIDTH-1:0] center_y;
   logic        [COORD_WIDTH-2:0] rect_width;
   logic        [COORD_WIDTH-2:0] rect_height;

   modport source (output valid, start_x, start_y, center_x, center_y,
                   rect_width, rect_height, input ready);
   modport sink   (input valid, start_x, start_y, center_x, center_y,
                   rect_width, rect_height, output ready);
endinterface

>>> hdl/clcr_rsp_if.sv
// ----------------------------------------------------------------------------
// clcr_rsp_if
// response channel: clip flag and edge crossing point
// ----------------------------------------------------------------------------
interface clcr_rsp_if #(
   parameter int COORD_WIDTH = 32
);
   logic                          valid;
   logic                          ready;
   logic                          valid_res;
   logic signed [COORD_WIDTH-1:0] clip_x;
   logic signed [COORD_WIDTH-1:0] clip_y;

   modport source (output valid, valid_res, clip_x, clip_y, input ready);
   modport sink   (input valid, valid_res, clip_x, clip_y, output ready);
endinterface

>>> hdl/clcr_divider.sv
// ----------------------------------------------------------------------------
// clcr_divider
// pipelined restoring divider, one quotient bit per stage, with sideband
// ----------------------------------------------------------------------------
module clcr_divider
   import clcr_pkg::*;
#(
   parameter int NUM_WIDTH  = 63,
   parameter int DEN_WIDTH  = 33,
   parameter int SIDE_WIDTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  clcr_ctl_type          in_ctl,
   input  logic [NUM_WIDTH-1:0]  in_num,
   input  logic [DEN_WIDTH-1:0]  in_den,
   input  logic [SIDE_WIDTH-1:0] in_side,
   output clcr_ctl_type          out_ctl,
   output logic [DEN_WIDTH-1:0]  out_quo,
   output logic [SIDE_WIDTH-1:0] out_side
);
   // quotient is known to fit DEN_WIDTH bits, so the top bits seed the remainder
   localparam int QW = DEN_WIDTH;
   localparam int TW = NUM_WIDTH - QW;

   clcr_ctl_type          ctl_ff  [QW];
   logic [DEN_WIDTH-1:0]  rem_ff  [QW];
   logic [QW-1:0]         low_ff  [QW];
   logic [DEN_WIDTH-1:0]  den_ff  [QW];
   logic [QW-1:0]         quo_ff  [QW];
   logic [SIDE_WIDTH-1:0] side_ff [QW];

   for (genvar k = 0; k < QW; k++) begin : g_stage
      clcr_ctl_type          ctl_prev;
      logic [DEN_WIDTH-1:0]  rem_prev;
      logic [QW-1:0]         low_prev;
      logic [DEN_WIDTH-1:0]  den_prev;
      logic [QW-1:0]         quo_prev;
      logic [SIDE_WIDTH-1:0] side_prev;
      logic [DEN_WIDTH:0]    trial;
      logic [DEN_WIDTH:0]    diff;
      logic                  fits;
      logic [DEN_WIDTH-1:0]  rem_in;
      logic [QW-1:0]         quo_in;

      if (k == 0) begin : g_first
         assign ctl_prev  = in_ctl;
         assign rem_prev  = {{(DEN_WIDTH-TW){1'b0}}, in_num[NUM_WIDTH-1:QW]};
         assign low_prev  = in_num[QW-1:0];
         assign den_prev  = in_den;
         assign quo_prev  = '0;
         assign side_prev = in_side;
      end else begin : g_next
         assign ctl_prev  = ctl_ff[k-1];
         assign rem_prev  = rem_ff[k-1];
         assign low_prev  = low_ff[k-1];
         assign den_prev  = den_ff[k-1];
         assign quo_prev  = quo_ff[k-1];
         assign side_prev = side_ff[k-1];
      end

      assign trial  = {rem_prev, low_prev[QW-1-k]};
      assign diff   = trial - {1'b0, den_prev};
      assign fits   = trial >= {1'b0, den_prev};
      assign rem_in = fits ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];
      assign quo_in = {quo_prev[QW-2:0], fits};

      always_ff @(posedge clock) begin
         if (reset) begin
            ctl_ff[k] <= '0;
         end else if (advance) begin
            ctl_ff[k] <= ctl_prev;
         end
         if (advance) begin
            rem_ff[k]  <= rem_in;
            low_ff[k]  <= low_prev;
            den_ff[k]  <= den_prev;
            quo_ff[k]  <= quo_in;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_ctl  = ctl_ff[QW-1];
   assign out_quo  = quo_ff[QW-1];
   assign out_side = side_ff[QW-1];

endmodule

>>> hdl/clcr_pass.sv
// ----------------------------------------------------------------------------
// clcr_pass
// one clip pass: outcode, multiply, divide, move the point onto the edge
// ----------------------------------------------------------------------------
module clcr_pass
   import clcr_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  clcr_ctl_type                  in_ctl,
   input  logic signed [COORD_WIDTH-1:0] in_px,
   input  logic signed [COORD_WIDTH-1:0] in_py,
   input  logic signed [COORD_WIDTH-1:0] in_cx,
   input  logic signed [COORD_WIDTH-1:0] in_cy,
   input  logic        [COORD_WIDTH-3:0] in_hw,
   input  logic        [COORD_WIDTH-3:0] in_hh,
   output clcr_ctl_type                  out_ctl,
   output logic signed [COORD_WIDTH-1:0] out_px,
   output logic signed [COORD_WIDTH-1:0] out_py,
   output logic signed [COORD_WIDTH-1:0] out_cx,
   output logic signed [COORD_WIDTH-1:0] out_cy,
   output logic        [COORD_WIDTH-3:0] out_hw,
   output logic        [COORD_WIDTH-3:0] out_hh
);
   localparam int W  = COORD_WIDTH;
   localparam int EW = W + 1;
   localparam int HW = W - 2;
   localparam int PW = EW + HW;

   typedef struct packed {
      logic                sel_y;
      logic                neg;
      logic [W-1:0]        edge_val;
      logic signed [W-1:0] px;
      logic signed [W-1:0] py;
      logic signed [W-1:0] cx;
      logic signed [W-1:0] cy;
      logic [HW-1:0]       hw;
      logic [HW-1:0]       hh;
   } side_type;

   // outcode and deltas
   logic signed [EW-1:0] px_e, py_e, cx_e, cy_e;
   logic signed [EW-1:0] xmax, xmin, ymax, ymin;
   logic signed [EW-1:0] dx, dy, d_o, d_a;
   logic                 top, bottom, right, left, sel_y;
   logic [EW-1:0]        mag_o, mag_a;
   logic signed [EW-1:0] edge_e;

   assign px_e = {in_px[W-1], in_px};
   assign py_e = {in_py[W-1], in_py};
   assign cx_e = {in_cx[W-1], in_cx};
   assign cy_e = {in_cy[W-1], in_cy};
   assign xmax = cx_e + $signed({3'b000, in_hw});
   assign xmin = cx_e - $signed({3'b000, in_hw});
   assign ymax = cy_e + $signed({3'b000, in_hh});
   assign ymin = cy_e - $signed({3'b000, in_hh});
   assign top    = py_e > ymax;
   assign bottom = !top && (py_e < ymin);
   assign right  = px_e > xmax;
   assign left   = !right && (px_e < xmin);
   assign sel_y  = top || bottom;
   assign dx  = px_e - cx_e;
   assign dy  = py_e - cy_e;
   assign d_o = sel_y ? dx : dy;
   assign d_a = sel_y ? dy : dx;
   assign mag_o = d_o[EW-1] ? -d_o : d_o;
   assign mag_a = d_a[EW-1] ? -d_a : d_a;

   always_comb begin
      priority if (top)    edge_e = ymax;
      else if (bottom)     edge_e = ymin;
      else if (right)      edge_e = xmax;
      else                 edge_e = xmin;
   end

   // stage 0 registers
   clcr_ctl_type  s0_ctl_ff;
   clcr_ctl_type  s0_ctl_in;
   side_type      s0_side_ff;
   side_type      s0_side_in;
   logic [EW-1:0] s0_mag_ff, s0_den_ff;
   logic [HW-1:0] s0_half_ff;

   always_comb begin
      s0_ctl_in       = in_ctl;
      s0_ctl_in.moved = top || bottom || right || left;
      s0_side_in.sel_y    = sel_y;
      s0_side_in.neg      = d_o[EW-1];
      s0_side_in.edge_val = edge_e[W-1:0];
      s0_side_in.px       = in_px;
      s0_side_in.py       = in_py;
      s0_side_in.cx       = in_cx;
      s0_side_in.cy       = in_cy;
      s0_side_in.hw       = in_hw;
      s0_side_in.hh       = in_hh;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff <= '0;
      end else if (advance) begin
         s0_ctl_ff <= s0_ctl_in;
      end
      if (advance) begin
         s0_side_ff <= s0_side_in;
         s0_mag_ff  <= mag_o;
         s0_den_ff  <= mag_a;
         s0_half_ff <= sel_y ? in_hh : in_hw;
      end
   end

   // stage 1: product
   clcr_ctl_type  s1_ctl_ff;
   side_type      s1_side_ff;
   logic [PW-1:0] s1_prod_ff;
   logic [PW-1:0] s1_prod_in;
   logic [EW-1:0] s1_den_ff;

   assign s1_prod_in = s0_mag_ff * s0_half_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff <= '0;
      end else if (advance) begin
         s1_ctl_ff <= s0_ctl_ff;
      end
      if (advance) begin
         s1_side_ff <= s0_side_ff;
         s1_prod_ff <= s1_prod_in;
         s1_den_ff  <= s0_den_ff;
      end
   end

   // divider
   clcr_ctl_type              dv_ctl;
   logic [EW-1:0]             dv_quo;
   logic [$bits(side_type)-1:0] dv_side_bits;
   side_type                  dv_side;

   clcr_divider #(
      .NUM_WIDTH  (PW),
      .DEN_WIDTH  (EW),
      .SIDE_WIDTH ($bits(side_type))
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .in_ctl   (s1_ctl_ff),
      .in_num   (s1_prod_ff),
      .in_den   (s1_den_ff),
      .in_side  (s1_side_ff),
      .out_ctl  (dv_ctl),
      .out_quo  (dv_quo),
      .out_side (dv_side_bits)
   );

   assign dv_side = side_type'(dv_side_bits);

   // final stage: crossing = center +/- quotient
   logic signed [EW-1:0] c_o, cross_e;
   logic signed [W-1:0]  nx_in, ny_in;
   clcr_ctl_type         out_ctl_ff;
   logic signed [W-1:0]  px_ff, py_ff, cx_ff, cy_ff;
   logic [HW-1:0]        hw_ff, hh_ff;

   assign c_o     = dv_side.sel_y ? {dv_side.cx[W-1], dv_side.cx}
                                  : {dv_side.cy[W-1], dv_side.cy};
   assign cross_e = dv_side.neg ? c_o - $signed(dv_quo) : c_o + $signed(dv_quo);

   always_comb begin
      nx_in = dv_side.px;
      ny_in = dv_side.py;
      if (dv_ctl.moved) begin
         if (dv_side.sel_y) begin
            nx_in = cross_e[W-1:0];
            ny_in = dv_side.edge_val;
         end else begin
            nx_in = dv_side.edge_val;
            ny_in = cross_e[W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_ctl_ff <= '0;
      end else if (advance) begin
         out_ctl_ff <= dv_ctl;
      end
      if (advance) begin
         px_ff <= nx_in;
         py_ff <= ny_in;
         cx_ff <= dv_side.cx;
         cy_ff <= dv_side.cy;
         hw_ff <= dv_side.hw;
         hh_ff <= dv_side.hh;
      end
   end

   assign out_ctl = out_ctl_ff;
   assign out_px  = px_ff;
   assign out_py  = py_ff;
   assign out_cx  = cx_ff;
   assign out_cy  = cy_ff;
   assign out_hw  = hw_ff;
   assign out_hh  = hh_ff;

endmodule

>>> hdl/clip_line_to_centered_rectangle.sv
// ----------------------------------------------------------------------------
// clip_line_to_centered_rectangle
// clips a start-to-center line against a centered rectangle, two passes
// ----------------------------------------------------------------------------
// usage
//   req_chan carries one word per line: start point, rectangle center (the
//   line's far end) and rectangle width and height, all Q16.16
//   rsp_chan returns one word per request, in order: valid_res is 1 when the
//   start lay outside the rectangle, and clip_x/clip_y give the edge crossing;
//   a start inside or on the boundary gives valid_res 0 and a zero point
// throughput: one word per cycle while rsp_chan is not stalling
// pipeline: each pass is outcode, multiply, a divider of COORD_WIDTH+1 one-bit
//   stages, and the point update; the two passes are followed by the output
//   register
// reset clears every stage valid bit; data registers are not reset
// a stall on rsp_chan freezes the whole pipeline in place, and req_chan.ready
//   stays high as long as the output register is empty or being drained
// ----------------------------------------------------------------------------
module clip_line_to_centered_rectangle
   import clcr_pkg::*;
#(
   parameter int COORD_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   clcr_req_if.sink   req_chan,
   clcr_rsp_if.source rsp_chan
);
   localparam int W = COORD_WIDTH;

   // pipeline advances whenever the output register can take a new word
   logic advance;
   logic rsp_valid_ff;

   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;

   // half sizes by a logical right shift (dropping the low bit) of the unsigned sizes
   clcr_ctl_type p1_in_ctl;

   always_comb begin
      p1_in_ctl       = '0;
      p1_in_ctl.valid = req_chan.valid;
   end

   // first pass: top or bottom edge first, else right or left
   clcr_ctl_type        p1_ctl;
   logic signed [W-1:0] p1_px, p1_py, p1_cx, p1_cy;
   logic [W-3:0]        p1_hw, p1_hh;

   clcr_pass #(.COORD_WIDTH(W)) u_pass1 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (p1_in_ctl),
      .in_px   (req_chan.start_x),
      .in_py   (req_chan.start_y),
      .in_cx   (req_chan.center_x),
      .in_cy   (req_chan.center_y),
      .in_hw   (req_chan.rect_width[W-2:1]),
      .in_hh   (req_chan.rect_height[W-2:1]),
      .out_ctl (p1_ctl),
      .out_px  (p1_px),
      .out_py  (p1_py),
      .out_cx  (p1_cx),
      .out_cy  (p1_cy),
      .out_hw  (p1_hw),
      .out_hh  (p1_hh)
   );

   // second pass: tag remembers whether the start was outside at all
   clcr_ctl_type p2_in_ctl;

   always_comb begin
      p2_in_ctl       = '0;
      p2_in_ctl.valid = p1_ctl.valid;
      p2_in_ctl.tag   = p1_ctl.moved;
   end

   clcr_ctl_type        p2_ctl;
   logic signed [W-1:0] p2_px, p2_py, p2_cx, p2_cy;
   logic [W-3:0]        p2_hw, p2_hh;

   clcr_pass #(.COORD_WIDTH(W)) u_pass2 (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .in_ctl  (p2_in_ctl),
      .in_px   (p1_px),
      .in_py   (p1_py),
      .in_cx   (p1_cx),
      .in_cy   (p1_cy),
      .in_hw   (p1_hw),
      .in_hh   (p1_hh),
      .out_ctl (p2_ctl),
      .out_px  (p2_px),
      .out_py  (p2_py),
      .out_cx  (p2_cx),
      .out_cy  (p2_cy),
      .out_hw  (p2_hw),
      .out_hh  (p2_hh)
   );

   // output register; inside starts report a zero point
   logic                valid_res_ff;
   logic signed [W-1:0] clip_x_ff, clip_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= p2_ctl.valid;
      end
      if (advance) begin
         valid_res_ff <= p2_ctl.tag;
         clip_x_ff    <= p2_ctl.tag ? p2_px : '0;
         clip_y_ff    <= p2_ctl.tag ? p2_py : '0;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.valid_res = valid_res_ff;
   assign rsp_chan.clip_x    = clip_x_ff;
   assign rsp_chan.clip_y    = clip_y_ff;

   // center and half sizes leaving the second pass have no further consumer
   logic unused_geom;
   assign unused_geom = ^{p2_cx, p2_cy, p2_hw, p2_hh};

   // an invalid clip always reports the zero point
   a_zero_when_inside: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.valid_res |-> rsp_chan.clip_x == '0 && rsp_chan.clip_y == '0)
      else $error("inside start did not give a zero point");

   // a second move only happens for a start that was outside
   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      p2_ctl.valid && p2_ctl.moved |-> p2_ctl.tag)
      else $error("second pass moved a point the first pass left alone");

   // nothing leaves the block right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_chan.valid)
      else $error("response valid right after reset");

   // a stalled output keeps the pipeline frozen
   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(p2_ctl) && $stable(p1_ctl))
      else $error("pipeline moved during a stall");

endmodule
